### hw/rtl/whrp_pkg.sv
package whrp_pkg;

  // Table size default
  localparam int DEFAULT_MAX_HOSTS = 64;

  // Field widths
  localparam int OP_W     = 3;
  localparam int IDX_W    = 6;
  localparam int WEIGHT_W = 16;
  localparam int RND_W    = 31;
  localparam int ERR_W    = 2;
  localparam int STATE_W  = 2;
  localparam int TOTAL_W  = 22;

  // Saturation limit of the reported total
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD        = 3'd0,
    OP_SET_STATUS = 3'd1,
    OP_SET_WEIGHT = 3'd2,
    OP_PICK       = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_INDEX = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd3;

  // Host state codes as reported by a read
  localparam logic [STATE_W-1:0] ST_NOTINIT = 2'd0;
  localparam logic [STATE_W-1:0] ST_AVAIL   = 2'd1;
  localparam logic [STATE_W-1:0] ST_UNAVAIL = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_SETUP,
    S_WALK
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // latch the incoming transaction
    logic exec;        // apply op and register the result
    logic div_start;   // clear the remainder, start reducing the draw
    logic div_step;    // one restoring division step
    logic walk_setup;  // remainder plus one, rewind the walk
    logic walk;        // issue next table read, test pending entry
    logic pick_done;   // register the pick result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            div_last;
    logic            hit;
  } stat_t;

endpackage

### hw/rtl/whrp_ctrl.sv
module whrp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  whrp_pkg::stat_t  stat,
  output whrp_pkg::cmd_t   cmd
);

  whrp_pkg::ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= whrp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      whrp_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = whrp_pkg::S_READ;
        end
      end
      // table read at the addressed slot is in flight
      whrp_pkg::S_READ: begin
        state_next = whrp_pkg::S_EXEC;
      end
      whrp_pkg::S_EXEC: begin
        if (stat.op == whrp_pkg::OP_PICK && !stat.empty) begin
          cmd.div_start = 1'b1;
          state_next    = whrp_pkg::S_DIV;
        end else begin
          cmd.exec   = 1'b1;
          state_next = whrp_pkg::S_IDLE;
        end
      end
      whrp_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = whrp_pkg::S_SETUP;
        end
      end
      whrp_pkg::S_SETUP: begin
        cmd.walk_setup = 1'b1;
        state_next     = whrp_pkg::S_WALK;
      end
      whrp_pkg::S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.hit) begin
          cmd.pick_done = 1'b1;
          state_next    = whrp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = whrp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/whrp_dp.sv
module whrp_dp #(
  parameter int MAX_HOSTS = whrp_pkg::DEFAULT_MAX_HOSTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  whrp_pkg::cmd_t                   cmd,
  output whrp_pkg::stat_t                  stat,
  input  logic [whrp_pkg::OP_W-1:0]        operation,
  input  logic [whrp_pkg::IDX_W-1:0]       host_index,
  input  logic                             new_availability,
  input  logic [whrp_pkg::WEIGHT_W-1:0]    new_weight,
  input  logic [whrp_pkg::RND_W-1:0]       random_value,
  output logic                             done,
  output logic [whrp_pkg::ERR_W-1:0]       error_code,
  output logic [whrp_pkg::IDX_W-1:0]       chosen_index,
  output logic [whrp_pkg::STATE_W-1:0]     host_state,
  output logic [whrp_pkg::WEIGHT_W-1:0]    host_weight_out,
  output logic [whrp_pkg::TOTAL_W-1:0]     weight_total
);

  localparam int WW     = whrp_pkg::WEIGHT_W;
  localparam int ADDR_W = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
  localparam int CNT_W  = $clog2(MAX_HOSTS + 1);
  localparam int SUM_W  = $clog2(MAX_HOSTS * ((2 ** WW) - 1) + 1);
  localparam int REM_W  = SUM_W + 1;
  localparam int CMPI_W = CNT_W + whrp_pkg::IDX_W;
  localparam int CMPT_W = (SUM_W > whrp_pkg::TOTAL_W) ? SUM_W : whrp_pkg::TOTAL_W;
  localparam int DCNT_W = $clog2(whrp_pkg::RND_W);

  // Latched transaction
  logic [whrp_pkg::OP_W-1:0]     op_q;
  logic [whrp_pkg::IDX_W-1:0]    idx_q;
  logic                          avail_q;
  logic [WW-1:0]                 wnew_q;
  logic [whrp_pkg::RND_W-1:0]    rnd_q;

  // Bookkeeping
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [REM_W-1:0]  rem;
  logic [DCNT_W-1:0] div_cnt;
  logic [ADDR_W-1:0] walk_addr;
  logic [ADDR_W-1:0] pend_idx;
  logic              pend;

  // Host table: {available, weight}
  logic [WW:0]       mem [MAX_HOSTS];
  logic [WW:0]       rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [WW:0]       wr_data;
  logic              wr_en;

  logic              rd_avail;
  logic [WW-1:0]     rd_w;
  logic              idx_ok;
  logic              full;
  logic [WW-1:0]     wclamp;
  logic [REM_W-1:0]  rem_sh;
  logic              rem_ge;
  logic [REM_W-1:0]  rd_w_ext;
  logic [whrp_pkg::ERR_W-1:0]   err_c;
  logic [whrp_pkg::IDX_W-1:0]   chosen_c;
  logic [whrp_pkg::STATE_W-1:0] state_c;
  logic [WW-1:0]                wout_c;
  logic [whrp_pkg::TOTAL_W-1:0] total_c;

  assign rd_avail = rd_data[WW];
  assign rd_w     = rd_data[WW-1:0];
  assign rd_w_ext = REM_W'(rd_w);
  assign idx_ok   = CMPI_W'(idx_q) < CMPI_W'(count);
  assign full     = (count == CNT_W'(MAX_HOSTS));
  assign wclamp   = (wnew_q == '0) ? WW'(1) : wnew_q;

  // Input latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      idx_q   <= host_index;
      avail_q <= new_availability;
      wnew_q  <= new_weight;
      rnd_q   <= random_value;
    end else if (cmd.div_step) begin
      rnd_q   <= rnd_q << 1;
    end
  end

  // Table memory, registered read
  assign rd_addr = cmd.walk ? walk_addr : ADDR_W'(idx_q);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Operation decode: table write, new total and result fields
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = ADDR_W'(idx_q);
    wr_data  = {rd_avail, rd_w};
    sum_next = sum;
    err_c    = whrp_pkg::ERR_OK;
    chosen_c = '0;
    state_c  = whrp_pkg::ST_NOTINIT;
    wout_c   = '0;
    unique case (op_q)
      whrp_pkg::OP_ADD: begin
        if (full) begin
          err_c = whrp_pkg::ERR_FULL;
        end else begin
          wr_en    = cmd.exec;
          wr_addr  = count[ADDR_W-1:0];
          wr_data  = {1'b1, WW'(1)};
          sum_next = sum + SUM_W'(1);
          chosen_c = whrp_pkg::IDX_W'(count);
        end
      end
      whrp_pkg::OP_SET_STATUS: begin
        if (!idx_ok) begin
          err_c = whrp_pkg::ERR_INDEX;
        end else begin
          wr_en   = cmd.exec;
          wr_data = {avail_q, rd_w};
          if (rd_avail && !avail_q) begin
            sum_next = sum - SUM_W'(rd_w);
          end else if (!rd_avail && avail_q) begin
            sum_next = sum + SUM_W'(rd_w);
          end
        end
      end
      whrp_pkg::OP_SET_WEIGHT: begin
        if (!idx_ok) begin
          err_c = whrp_pkg::ERR_INDEX;
        end else begin
          wr_en   = cmd.exec;
          wr_data = {rd_avail, wclamp};
          if (rd_avail) begin
            sum_next = sum - SUM_W'(rd_w) + SUM_W'(wclamp);
          end
        end
      end
      whrp_pkg::OP_PICK: begin
        if (sum == '0) begin
          err_c = whrp_pkg::ERR_EMPTY;
        end
        chosen_c = whrp_pkg::IDX_W'(pend_idx);
      end
      whrp_pkg::OP_READ: begin
        if (!idx_ok) begin
          err_c = whrp_pkg::ERR_INDEX;
        end else begin
          state_c = rd_avail ? whrp_pkg::ST_AVAIL : whrp_pkg::ST_UNAVAIL;
          wout_c  = rd_w;
        end
      end
      default: begin
      end
    endcase
    // empty pick reports slot zero
    if (op_q == whrp_pkg::OP_PICK && cmd.exec) begin
      chosen_c = '0;
    end
  end

  // Reported total saturates
  assign total_c = (CMPT_W'(sum_next) > CMPT_W'(whrp_pkg::TOTAL_MAX)) ?
                   whrp_pkg::TOTAL_MAX : whrp_pkg::TOTAL_W'(sum_next);

  // Host count and running total
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
    end else if (cmd.exec) begin
      sum <= sum_next;
      if (op_q == whrp_pkg::OP_ADD && !full) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Restoring division step: shift in one draw bit, subtract if it fits
  assign rem_sh = {rem[SUM_W-1:0], rnd_q[whrp_pkg::RND_W-1]};
  assign rem_ge = rem_sh >= REM_W'(sum);

  // Remainder, division counter and walk pointer
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_ge ? (rem_sh - REM_W'(sum)) : rem_sh;
      div_cnt <= div_cnt + DCNT_W'(1);
    end else if (cmd.walk_setup) begin
      rem       <= rem + REM_W'(1);
      walk_addr <= '0;
      pend      <= 1'b0;
    end else if (cmd.walk) begin
      walk_addr <= walk_addr + ADDR_W'(1);
      pend      <= 1'b1;
      pend_idx  <= walk_addr;
      if (pend && rd_avail) begin
        rem <= rem - rd_w_ext;
      end
    end
  end

  // Status to controller
  assign stat.op       = op_q;
  assign stat.empty    = (sum == '0);
  assign stat.div_last = (div_cnt == DCNT_W'(whrp_pkg::RND_W - 1));
  assign stat.hit      = pend && rd_avail && (rd_w_ext >= rem);

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec | cmd.pick_done;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.pick_done) begin
      error_code      <= err_c;
      chosen_index    <= chosen_c;
      host_state      <= state_c;
      host_weight_out <= wout_c;
      weight_total    <= total_c;
    end
  end

endmodule

### hw/rtl/weighted_random_host_picker.sv
// Add, set status, set weight and read: a table read at the addressed slot, then the op is
// applied and the result strobed. Pick: bit-serial modulo of the draw by the total, a setup
// step, then one table read per slot walked plus one for the registered read.
// One transaction at a time; the next is taken as the result shows.
// Reset: synchronous; empties the table (host count and total to zero), no clearing pass.
// Each result is shown on done for one cycle; the receiver cannot stall.
module weighted_random_host_picker #(
  parameter int MAX_HOSTS = whrp_pkg::DEFAULT_MAX_HOSTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [whrp_pkg::OP_W-1:0]        operation,
  input  logic [whrp_pkg::IDX_W-1:0]       host_index,
  input  logic                             new_availability,
  input  logic [whrp_pkg::WEIGHT_W-1:0]    new_weight,
  input  logic [whrp_pkg::RND_W-1:0]       random_value,
  output logic                             done,
  output logic [whrp_pkg::ERR_W-1:0]       error_code,
  output logic [whrp_pkg::IDX_W-1:0]       chosen_index,
  output logic [whrp_pkg::STATE_W-1:0]     host_state,
  output logic [whrp_pkg::WEIGHT_W-1:0]    host_weight_out,
  output logic [whrp_pkg::TOTAL_W-1:0]     weight_total
);

  whrp_pkg::cmd_t  cmd;
  whrp_pkg::stat_t stat;

  // Sequencer
  whrp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Host table, totals, divider and walk
  whrp_dp #(
    .MAX_HOSTS (MAX_HOSTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .operation        (operation),
    .host_index       (host_index),
    .new_availability (new_availability),
    .new_weight       (new_weight),
    .random_value     (random_value),
    .done             (done),
    .error_code       (error_code),
    .chosen_index     (chosen_index),
    .host_state       (host_state),
    .host_weight_out  (host_weight_out),
    .weight_total     (weight_total)
  );

endmodule
